[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/gpwr_pkg.sv]
// Package: kinds, status codes and size defaults for the path weight relaxation block.
package gpwr_pkg;

  localparam int NODES_DEF       = 1024;
  localparam int MAX_EDGES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 1024;

  localparam int NODE_FW   = 10;
  localparam int WEIGHT_FW = 32;
  localparam int KIND_FW   = 3;
  localparam int STATUS_FW = 2;

  typedef enum logic [KIND_FW-1:0] {
    K_CLEAR  = 3'd0,
    K_ADD    = 3'd1,
    K_START  = 3'd2,
    K_SEED   = 3'd3,
    K_RUN    = 3'd4,
    K_READ   = 3'd5
  } kind_t;

  typedef enum logic [STATUS_FW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_OVF    = 2'd2,
    ST_NONPOS = 2'd3
  } status_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctl_t;

  // Queue status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[hdl/gpwr_if.sv]
// Channel interfaces: request items in, result items out.
interface gpwr_in_if import gpwr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_FW-1:0]   kind;
  logic [NODE_FW-1:0]   node;
  logic [NODE_FW-1:0]   neighbor;
  logic [WEIGHT_FW-1:0] weight;
  modport source (output valid, kind, node, neighbor, weight, input ready);
  modport sink   (input valid, kind, node, neighbor, weight, output ready);
endinterface

interface gpwr_out_if import gpwr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WEIGHT_FW-1:0] node_weight;
  logic                 reached;
  logic [STATUS_FW-1:0] status;
  modport source (output valid, node_weight, reached, status, input ready);
  modport sink   (input valid, node_weight, reached, status, output ready);
endinterface

[hdl/graph_path_weight_relaxation.sv]
// Top level: graph memories, sequencer and result register of the path weight relaxation.
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid / ready  | kind, node, neighbor, weight
//  out_ch  | out | valid / ready  | node_weight, reached, status
//
// After reset a clearing pass clears edge counts and reached bits.
// Add edge and read go through a read state and a write or capture state; clear graph and start
// trace sweep every node. A run pops a node, reads its edge count and weight, then per edge reads
// the target and, unless it is out of range, the neighbor, then relaxes it: one memory port per step.
// One item at a time; the result register lets the next item in while the result waits.
module graph_path_weight_relaxation import gpwr_pkg::*; #(
  parameter int NODES       = NODES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gpwr_in_if.sink      in_ch,
  gpwr_out_if.source   out_ch
);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int ED = NODES * (2 ** EW);

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_CLREC = 14'b00000000000100,
    S_CLRRF = 14'b00000000001000,
    S_ADDRD = 14'b00000000010000,
    S_ADDWR = 14'b00000000100000,
    S_RDRD  = 14'b00000001000000,
    S_RDCAP = 14'b00000010000000,
    S_POP   = 14'b00000100000000,
    S_ROOTA = 14'b00001000000000,
    S_ROOTB = 14'b00010000000000,
    S_EDGEA = 14'b00100000000000,
    S_EDGEB = 14'b01000000000000,
    S_NB    = 14'b10000000000000
  } state_t;

  // Separate done state is folded into a flag so results wait in one place
  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  // latched request
  logic [KIND_FW-1:0]   kind_r;
  logic [NW-1:0]        node_r;
  logic [WEIGHT_FW-1:0] w_r;
  logic [NODE_FW-1:0]   nbr_hold_r;

  // working registers
  logic [NW-1:0]        sw_r, sw_nxt;
  logic [NW-1:0]        root_r, root_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [WEIGHT_FW-1:0] rootw_r, rootw_nxt, cand_r, cand_nxt;
  logic [NW-1:0]        nb_r, nb_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [WEIGHT_FW-1:0] resw_r, resw_nxt;
  logic                 resr_r, resr_nxt, chk_r, chk_nxt;
  status_t              ress_r, ress_nxt;

  // result register
  logic                 ov_r;
  logic [WEIGHT_FW-1:0] ow_r;
  logic                 orch_r;
  status_t              ost_r;

  // memories
  logic [CW-1:0]        ec_mem [NODES];
  logic                 rf_mem [NODES];
  logic [WEIGHT_FW-1:0] pw_mem [NODES];
  logic [NODE_FW-1:0]   et_mem [ED];
  logic [WEIGHT_FW-1:0] cs_mem [ED];

  logic [NW-1:0]        ec_ra, rf_ra, pw_ra, ec_wa, rf_wa, pw_wa;
  logic [NW+EW-1:0]     ed_ra, ed_wa;
  logic                 ec_we, rf_we, pw_we, ed_we;
  logic [CW-1:0]        ec_wd, ec_rd_r;
  logic                 rf_wd, rf_rd_r;
  logic [WEIGHT_FW-1:0] pw_wd, pw_rd_r, cs_rd_r;
  logic [NODE_FW-1:0]   et_rd_r;

  // queue and shared unit
  q_ctl_t               q_ctl;
  q_stat_t              q_stat;
  logic [NW-1:0]        q_wd, q_rd;
  logic [WEIGHT_FW-1:0] u_sum;
  logic                 u_heavier;

  logic                 acc, in_node_ok, in_nb_ok, nb_ok, upd;
  logic [NW-1:0]        in_node_idx;

  assign acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !done_r;
  assign in_node_ok  = 32'(in_ch.node) < NODES;
  assign in_nb_ok    = 32'(in_ch.neighbor) < NODES;
  assign in_node_idx = NW'(in_ch.node);
  assign nb_ok       = 32'(et_rd_r) < NODES;

  gpwr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .NW(NW)) u_queue (
    .clk(clk), .rst_n(rst_n), .ctl(q_ctl), .wdata(q_wd), .rdata(q_rd), .stat(q_stat)
  );

  gpwr_relax_unit u_unit (
    .a(rootw_r), .b(cs_rd_r), .old_w(pw_rd_r), .cand(cand_r),
    .sum(u_sum), .heavier(u_heavier)
  );

  // relax decision on the neighbor read back
  assign upd = (ec_rd_r != '0) && (!rf_rd_r || u_heavier);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    sw_nxt    = sw_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    rootw_nxt = rootw_r;
    cand_nxt  = cand_r;
    nb_nxt    = nb_r;
    ovf_nxt   = ovf_r;
    resw_nxt  = resw_r;
    resr_nxt  = resr_r;
    ress_nxt  = ress_r;
    chk_nxt   = chk_r;
    q_ctl     = '0;
    q_wd      = node_r;
    ec_ra = node_r;  rf_ra = node_r;  pw_ra = node_r;
    ec_we = 1'b0;    ec_wa = sw_r;    ec_wd = '0;
    rf_we = 1'b0;    rf_wa = sw_r;    rf_wd = 1'b0;
    pw_we = 1'b0;    pw_wa = node_r;  pw_wd = w_r;
    ed_we = 1'b0;    ed_wa = {node_r, ec_rd_r[EW-1:0]};
    ed_ra = {root_r, idx_r[EW-1:0]};

    if (done_r && (!ov_r || out_ch.ready)) done_nxt = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ec_we = 1'b1;
        rf_we = 1'b1;
        sw_nxt = sw_r + NW'(1);
        if (32'(sw_r) == NODES - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          resw_nxt = '0;
          resr_nxt = 1'b0;
          ress_nxt = ST_OK;
          chk_nxt  = 1'b0;
          sw_nxt   = '0;
          done_nxt = 1'b1;
          case (in_ch.kind)
            K_CLEAR: begin
              done_nxt  = 1'b0;
              state_nxt = S_CLREC;
            end
            K_ADD: begin
              if (in_node_ok && in_nb_ok) begin
                done_nxt  = 1'b0;
                state_nxt = S_ADDRD;
              end
            end
            K_START: begin
              q_ctl.clear = 1'b1;
              ovf_nxt     = 1'b0;
              done_nxt    = 1'b0;
              state_nxt   = S_CLRRF;
            end
            K_SEED: begin
              if (in_node_ok) begin
                if (in_ch.weight == '0) begin
                  ress_nxt = ST_NONPOS;
                end else begin
                  pw_we = 1'b1;  pw_wa = in_node_idx;  pw_wd = in_ch.weight;
                  rf_we = 1'b1;  rf_wa = in_node_idx;  rf_wd = 1'b1;
                  q_ctl.push = 1'b1;
                  q_wd = in_node_idx;
                  if (q_stat.full) ovf_nxt = 1'b1;
                  chk_nxt = 1'b1;
                end
              end
            end
            K_RUN: begin
              chk_nxt   = 1'b1;
              done_nxt  = 1'b0;
              state_nxt = S_POP;
            end
            K_READ: begin
              if (in_node_ok) begin
                chk_nxt   = 1'b1;
                done_nxt  = 1'b0;
                state_nxt = S_RDRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLREC: begin
        ec_we  = 1'b1;
        sw_nxt = sw_r + NW'(1);
        if (32'(sw_r) == NODES - 1) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLRRF: begin
        rf_we  = 1'b1;
        sw_nxt = sw_r + NW'(1);
        if (32'(sw_r) == NODES - 1) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ADDRD: begin
        state_nxt = S_ADDWR;
      end
      S_ADDWR: begin
        if (32'(ec_rd_r) >= MAX_EDGES) begin
          ress_nxt = ST_FULL;
        end else begin
          ed_we = 1'b1;
          ec_we = 1'b1;
          ec_wa = node_r;
          ec_wd = ec_rd_r + CW'(1);
        end
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDRD: begin
        state_nxt = S_RDCAP;
      end
      S_RDCAP: begin
        if (rf_rd_r) begin
          resw_nxt = pw_rd_r;
          resr_nxt = 1'b1;
        end
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if (q_stat.empty) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          q_ctl.pop = 1'b1;
          state_nxt = S_ROOTA;
        end
      end
      S_ROOTA: begin
        root_nxt  = q_rd;
        ec_ra     = q_rd;
        pw_ra     = q_rd;
        state_nxt = S_ROOTB;
      end
      S_ROOTB: begin
        cnt_nxt   = (32'(ec_rd_r) > MAX_EDGES) ? CW'(MAX_EDGES) : ec_rd_r;
        rootw_nxt = pw_rd_r;
        idx_nxt   = '0;
        state_nxt = S_EDGEA;
      end
      S_EDGEA: begin
        if (idx_r == cnt_r) state_nxt = S_POP;
        else                state_nxt = S_EDGEB;
      end
      S_EDGEB: begin
        if (!nb_ok) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_EDGEA;
        end else begin
          nb_nxt    = NW'(et_rd_r);
          ec_ra     = NW'(et_rd_r);
          rf_ra     = NW'(et_rd_r);
          pw_ra     = NW'(et_rd_r);
          cand_nxt  = u_sum;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (upd) begin
          pw_we = 1'b1;  pw_wa = nb_r;  pw_wd = cand_r;
          rf_we = 1'b1;  rf_wa = nb_r;  rf_wd = 1'b1;
          q_ctl.push = 1'b1;
          q_wd = nb_r;
          if (q_stat.full) ovf_nxt = 1'b1;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_EDGEA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      done_r  <= 1'b0;
      sw_r    <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      sw_r    <= sw_nxt;
      ovf_r   <= ovf_nxt;
      if (done_r && (!ov_r || out_ch.ready)) ov_r <= 1'b1;
      else if (out_ch.ready)                 ov_r <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r     <= in_ch.kind;
      node_r     <= in_node_idx;
      w_r        <= in_ch.weight;
      nbr_hold_r <= in_ch.neighbor;
    end
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    rootw_r <= rootw_nxt;
    cand_r  <= cand_nxt;
    nb_r    <= nb_nxt;
    resw_r  <= resw_nxt;
    resr_r  <= resr_nxt;
    ress_r  <= ress_nxt;
    chk_r   <= chk_nxt;
    if (done_r && (!ov_r || out_ch.ready)) begin
      ow_r   <= resw_r;
      orch_r <= resr_r;
      ost_r  <= (chk_r && ovf_r && kind_r != K_ADD) ? ST_OVF : ress_r;
    end
  end

  // graph memories
  always_ff @(posedge clk) begin
    if (ec_we) ec_mem[ec_wa] <= ec_wd;
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (pw_we) pw_mem[pw_wa] <= pw_wd;
    if (ed_we) begin
      et_mem[ed_wa] <= nbr_hold_r;
      cs_mem[ed_wa] <= w_r;
    end
    ec_rd_r <= ec_mem[ec_ra];
    rf_rd_r <= rf_mem[rf_ra];
    pw_rd_r <= pw_mem[pw_ra];
    et_rd_r <= et_mem[ed_ra];
    cs_rd_r <= cs_mem[ed_ra];
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.node_weight = ow_r;
  assign out_ch.reached     = orch_r;
  assign out_ch.status      = ost_r;
endmodule

[hdl/gpwr_queue.sv]
// Work queue: FIFO of node indexes with pointers that wrap at twice the depth and registered read.
module gpwr_queue import gpwr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NW          = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  q_ctl_t        ctl,
  input  logic [NW-1:0] wdata,
  output logic [NW-1:0] rdata,
  output q_stat_t       stat
);
  localparam int QW  = $clog2(2 * QUEUE_DEPTH);
  localparam int QIW = $clog2(QUEUE_DEPTH);

  logic [NW-1:0] mem [QUEUE_DEPTH];
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QW-1:0] len;
  logic [NW-1:0] rdata_r;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (32'(p) == 2 * QUEUE_DEPTH - 1) ? '0 : p + QW'(1);
  endfunction

  function automatic logic [QIW-1:0] ptr_idx(input logic [QW-1:0] p);
    return (32'(p) >= QUEUE_DEPTH) ? QIW'(p - QW'(QUEUE_DEPTH)) : QIW'(p);
  endfunction

  // occupancy, pointers modulo twice the depth
  assign len = (tail_r >= head_r) ? tail_r - head_r
                                  : QW'(32'(tail_r) + 2 * QUEUE_DEPTH - 32'(head_r));
  assign stat.empty = (len == '0);
  assign stat.full  = (32'(len) >= QUEUE_DEPTH);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.pop && !stat.empty) head_nxt = ptr_inc(head_r);
      if (ctl.push && !stat.full) tail_nxt = ptr_inc(tail_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (ctl.push && !stat.full && !ctl.clear) mem[ptr_idx(tail_r)] <= wdata;
    rdata_r <= mem[ptr_idx(head_r)];
  end

  assign rdata = rdata_r;
endmodule

[hdl/gpwr_relax_unit.sv]
// Shared arithmetic: saturating weight add and the heavier-than compare.
module gpwr_relax_unit import gpwr_pkg::*; (
  input  logic [WEIGHT_FW-1:0] a,
  input  logic [WEIGHT_FW-1:0] b,
  input  logic [WEIGHT_FW-1:0] old_w,
  input  logic [WEIGHT_FW-1:0] cand,
  output logic [WEIGHT_FW-1:0] sum,
  output logic                 heavier
);
  logic [WEIGHT_FW:0] raw;

  assign raw     = {1'b0, a} + {1'b0, b};
  assign sum     = raw[WEIGHT_FW] ? '1 : raw[WEIGHT_FW-1:0];
  assign heavier = old_w > cand;
endmodule

[hdl/gpwr_checker.sv]
// Port-level checker for the path weight relaxation block, bound to the top level.
`include "assert_macros.svh"

module gpwr_checker import gpwr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WEIGHT_FW-1:0] out_node_weight,
  input logic                 out_reached,
  input logic [STATUS_FW-1:0] out_status
);
  // a stalled result stays valid and holds its status
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
  // an unreached answer carries no weight
  `ASSERT_IMP(a_unreached_zero, clk, rst_n, out_valid && !out_reached, out_node_weight == '0)
  // reached only comes with a read, never with a seed or full-list status
  `ASSERT_IMP(a_reached_status, clk, rst_n, out_valid && out_reached,
              out_status == ST_OK || out_status == ST_OVF)
  // an accepted item closes the input until its work is done
  `ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind graph_path_weight_relaxation gpwr_checker u_gpwr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_node_weight(out_ch.node_weight), .out_reached(out_ch.reached),
  .out_status(out_ch.status)
);
